FILE: sv/dmt_pkg.sv
// ----------------------------------------------------------------------------
// dmt_pkg
// Shared types and constants for the differential Manchester OOK tone
// transmitter.
// ----------------------------------------------------------------------------
package dmt_pkg;

  localparam int unsigned HalfW   = 20;
  localparam int unsigned CyclesW = 10;
  localparam int unsigned SilentW = 24;
  localparam int unsigned TickW   = 24;
  localparam int unsigned HalvesW = 11;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;

  localparam logic [HalfW-1:0]   HALF_RESET   = 20'd16949;
  localparam logic [CyclesW-1:0] CYCLES_RESET = 10'd59;
  localparam logic [SilentW-1:0] SILENT_RESET = 24'd1000000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HALF_PERIOD = 2'd0,
    REG_TONE_CYCLES = 2'd1,
    REG_SILENT      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [HalfW-1:0]   half_period_ticks;
    logic [CyclesW-1:0] tone_cycles;
    logic [SilentW-1:0] silent_ticks;
  } cfg_t;

  typedef struct packed {
    logic              pin_level;
    logic              bit_taken;
    logic [CountW-1:0] bit_count;
    logic              current_bit;
    logic [CountW-1:0] symbol_count;
    logic              symbol_level;
  } result_t;

endpackage

FILE: sv/dmt_core.sv
// ----------------------------------------------------------------------------
// dmt_core
// Symbol sequencer state and the single-tick update: bit start, pin level,
// span counters and symbol end.
// ----------------------------------------------------------------------------
module dmt_core import dmt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  logic    data_bit,
  input  cfg_t    cfg,
  output result_t res
);

  logic              polarity, polarity_next;
  logic              second_half, second_half_next;
  logic              in_symbol, in_symbol_next;
  logic [TickW-1:0]  tick_counter, tick_counter_next;
  logic [HalvesW-1:0] half_counter, half_counter_next;
  logic [CountW-1:0] bits_started, bits_started_next;
  logic [CountW-1:0] symbols_started, symbols_started_next;
  logic              held_bit, held_bit_next;

  logic               start;
  logic               pol_eff;
  logic               sec_eff;
  logic [TickW-1:0]   tick_eff, tick_inc;
  logic [HalvesW-1:0] half_eff, half_inc, halves;
  logic [HalfW-1:0]   hp;
  logic [SilentW-1:0] st;
  logic [CyclesW-1:0] tc;
  logic               span_end, sym_end;

  always_comb begin
    start   = !in_symbol;
    pol_eff = (start && !data_bit) ? !polarity : polarity;
    held_bit_next     = start ? data_bit : held_bit;
    bits_started_next = start ? bits_started + 1'b1 : bits_started;
    sec_eff  = start ? 1'b0 : second_half;
    tick_eff = start ? '0 : tick_counter;
    half_eff = start ? '0 : half_counter;

    // zero-valued registers count as one
    hp = (cfg.half_period_ticks == '0) ? HalfW'(1) : cfg.half_period_ticks;
    tc = (cfg.tone_cycles == '0) ? CyclesW'(1) : cfg.tone_cycles;
    st = (cfg.silent_ticks == '0) ? SilentW'(1) : cfg.silent_ticks;
    halves = {tc, 1'b0};

    tick_inc = tick_eff + 1'b1;
    half_inc = half_eff + 1'b1;
    if (pol_eff) begin
      span_end = tick_inc >= TickW'(hp);
      sym_end  = span_end && (half_inc >= halves);
    end else begin
      span_end = tick_inc >= st;
      sym_end  = span_end;
    end

    tick_counter_next = span_end ? '0 : tick_inc;
    if (sym_end) begin
      half_counter_next = '0;
    end else if (pol_eff && span_end) begin
      half_counter_next = half_inc;
    end else begin
      half_counter_next = half_eff;
    end

    polarity_next        = pol_eff;
    second_half_next     = sec_eff;
    in_symbol_next       = 1'b1;
    symbols_started_next = symbols_started;
    if (sym_end) begin
      if (!sec_eff) begin
        second_half_next     = 1'b1;
        polarity_next        = !pol_eff;
        symbols_started_next = symbols_started + 1'b1;
      end else begin
        second_half_next = 1'b0;
        in_symbol_next   = 1'b0;
      end
    end

    res.pin_level    = pol_eff & ~half_eff[0];
    res.bit_taken    = start;
    res.bit_count    = bits_started_next;
    res.current_bit  = held_bit_next;
    res.symbol_count = symbols_started;
    res.symbol_level = pol_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      polarity        <= 1'b0;
      second_half     <= 1'b0;
      in_symbol       <= 1'b0;
      tick_counter    <= '0;
      half_counter    <= '0;
      bits_started    <= '0;
      symbols_started <= '0;
      held_bit        <= 1'b0;
    end else if (step) begin
      polarity        <= polarity_next;
      second_half     <= second_half_next;
      in_symbol       <= in_symbol_next;
      tick_counter    <= tick_counter_next;
      half_counter    <= half_counter_next;
      bits_started    <= bits_started_next;
      symbols_started <= symbols_started_next;
      held_bit        <= held_bit_next;
    end
  end

endmodule

FILE: sv/diff_manchester_ook_tone_tx.sv
// ----------------------------------------------------------------------------
// diff_manchester_ook_tone_tx
// Differential Manchester transmitter with on-off keyed tone symbols; one
// input transfer per tick, one result transfer per tick.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_stall  | data_bit
//  out      | out_valid / out_stall| pin_level, bit_taken, bit_count,
//           |                      | current_bit, symbol_count, symbol_level
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One tick per cycle while in_stall is low: the state update and the result are
// computed combinationally and the result lands in the output register.
// in_stall is high only while the output register is full and stalled.
// cfg_ready is always high; writes take effect on the next tick.
// Reset clears the sequencer and reloads the register defaults.
// ----------------------------------------------------------------------------
module diff_manchester_ook_tone_tx import dmt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               data_bit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               pin_level,
  output logic               bit_taken,
  output logic [CountW-1:0]  bit_count,
  output logic               current_bit,
  output logic [CountW-1:0]  symbol_count,
  output logic               symbol_level,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  cfg_t    cfg;
  result_t res;
  result_t res_q;
  logic    step;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign step      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= HALF_RESET;
      cfg.tone_cycles       <= CYCLES_RESET;
      cfg.silent_ticks      <= SILENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HALF_PERIOD: cfg.half_period_ticks <= cfg_data[HalfW-1:0];
        REG_TONE_CYCLES: cfg.tone_cycles       <= cfg_data[CyclesW-1:0];
        REG_SILENT:      cfg.silent_ticks      <= cfg_data[SilentW-1:0];
        default: ;
      endcase
    end
  end

  dmt_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .data_bit (data_bit),
    .cfg      (cfg),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign pin_level    = res_q.pin_level;
  assign bit_taken    = res_q.bit_taken;
  assign bit_count    = res_q.bit_count;
  assign current_bit  = res_q.current_bit;
  assign symbol_count = res_q.symbol_count;
  assign symbol_level = res_q.symbol_level;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted tick produced no result");

  a_pin_only_in_tone: assert property (@(posedge clk) disable iff (rst)
    out_valid && pin_level |-> symbol_level)
    else $error("pin high during silent symbol");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bit_count) && $stable(symbol_count))
    else $error("stalled result changed");

  a_taken_counts: assert property (@(posedge clk) disable iff (rst)
    step && res.bit_taken |=> bit_count != $past(u_core.bits_started))
    else $error("bit start did not advance bit count");

endmodule

FILE: bench/diff_manchester_ook_tone_tx_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_manchester_ook_tone_tx_tb
// Self-checking bench for the differential Manchester OOK tone transmitter.
// A scoreboard class carries its own model of the tick sequencer. Each input
// transfer is predicted from that model, and each result transfer is checked
// field by field. Stimulus covers the reset defaults, zero registers, masked
// register data, the unmapped register index and mid-symbol register changes.
// Random phases with bursty input and patterned output stalls follow, one of
// them with a long output hold-off.
// ----------------------------------------------------------------------------
module diff_manchester_ook_tone_tx_tb import dmt_pkg::*; ();

  localparam logic [CfgIdxW-1:0] REG_UNMAPPED = 2'd3;
  localparam int NUM_PHASES   = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE       = 4;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               data_bit = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               pin_level;
  logic               bit_taken;
  logic [CountW-1:0]  bit_count;
  logic               current_bit;
  logic [CountW-1:0]  symbol_count;
  logic               symbol_level;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  bit idling = 1'b0;
  bit long_hold = 1'b0;

  diff_manchester_ook_tone_tx dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_bit     (data_bit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pin_level    (pin_level),
    .bit_taken    (bit_taken),
    .bit_count    (bit_count),
    .current_bit  (current_bit),
    .symbol_count (symbol_count),
    .symbol_level (symbol_level),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  class tone_tx_scoreboard;
    bit [HalfW-1:0]   hp_ticks;
    bit [CyclesW-1:0] tone_cycles;
    bit [SilentW-1:0] silent_ticks;
    bit               polarity;
    bit               second_half;
    bit               in_symbol;
    bit               held_bit;
    bit [TickW-1:0]   tick_cnt;
    bit [HalvesW-1:0] half_cnt;
    bit [CountW-1:0]  bits_started;
    bit [CountW-1:0]  symbols_started;
    result_t          expected_ticks[$];
    int               failures;

    function new();
      hp_ticks        = HALF_RESET;
      tone_cycles     = CYCLES_RESET;
      silent_ticks    = SILENT_RESET;
      polarity        = 1'b0;
      second_half     = 1'b0;
      in_symbol       = 1'b0;
      held_bit        = 1'b0;
      tick_cnt        = '0;
      half_cnt        = '0;
      bits_started    = '0;
      symbols_started = '0;
      failures        = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
      case (idx)
        REG_HALF_PERIOD: hp_ticks     = value[HalfW-1:0];
        REG_TONE_CYCLES: tone_cycles  = value[CyclesW-1:0];
        REG_SILENT:      silent_ticks = value[SilentW-1:0];
        default: ;
      endcase
    endfunction

    function void close_symbol();
      tick_cnt = '0;
      half_cnt = '0;
      if (!second_half) begin
        second_half     = 1'b1;
        polarity        = ~polarity;
        symbols_started = symbols_started + 1'b1;
      end else begin
        second_half = 1'b0;
        in_symbol   = 1'b0;
      end
    endfunction

    // one tick: status reflects state during the tick, counters advance after
    function void note_tick(logic d);
      result_t          r;
      bit [TickW-1:0]   span;
      bit [HalvesW-1:0] halves;
      r.bit_taken = 1'b0;
      if (!in_symbol) begin
        r.bit_taken  = 1'b1;
        bits_started = bits_started + 1'b1;
        held_bit     = d;
        if (!held_bit) polarity = ~polarity;
        in_symbol   = 1'b1;
        second_half = 1'b0;
        tick_cnt    = '0;
        half_cnt    = '0;
      end
      r.pin_level    = polarity & ~half_cnt[0];
      r.bit_count    = bits_started;
      r.current_bit  = held_bit;
      r.symbol_count = symbols_started;
      r.symbol_level = polarity;
      expected_ticks.push_back(r);

      tick_cnt = tick_cnt + 1'b1;
      if (polarity) begin
        span   = (hp_ticks == '0) ? TickW'(1) : TickW'(hp_ticks);
        halves = (tone_cycles == '0) ? HalvesW'(2) : {tone_cycles, 1'b0};
        if (tick_cnt >= span) begin
          tick_cnt = '0;
          half_cnt = half_cnt + 1'b1;
          if (half_cnt >= halves) close_symbol();
        end
      end else begin
        span = (silent_ticks == '0) ? TickW'(1) : silent_ticks;
        if (tick_cnt >= span) close_symbol();
      end
    endfunction

    function void compare(string field, logic [CountW-1:0] want, logic [CountW-1:0] got);
      if (got !== want) begin
        failures++;
        $error("%s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_ticks.size() == 0) begin
        failures++;
        $error("result transfer with no tick pending");
        return;
      end
      want = expected_ticks.pop_front();
      compare("pin_level",    CountW'(want.pin_level),    CountW'(got.pin_level));
      compare("bit_taken",    CountW'(want.bit_taken),    CountW'(got.bit_taken));
      compare("bit_count",    want.bit_count,             got.bit_count);
      compare("current_bit",  CountW'(want.current_bit),  CountW'(got.current_bit));
      compare("symbol_count", want.symbol_count,          got.symbol_count);
      compare("symbol_level", CountW'(want.symbol_level), CountW'(got.symbol_level));
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    function void report_leftovers();
      if (expected_ticks.size() != 0) begin
        failures++;
        $error("%0d expected ticks never arrived", expected_ticks.size());
        expected_ticks.delete();
      end
    endfunction
  endclass

  tone_tx_scoreboard sb;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_tick(data_bit);
      if (out_valid && !out_stall)
        sb.check_result({pin_level, bit_taken, bit_count, current_bit,
                         symbol_count, symbol_level});
    end
  end

  // receiver: stall segments of random density, plus one long hold-off
  initial begin : result_side
    int seg_left;
    int stall_pct;
    bit hold_served;
    seg_left    = 0;
    stall_pct   = 0;
    hold_served = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 4);
        case ($urandom_range(3, 0))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      out_stall <= idling && ($urandom_range(99, 0) < stall_pct);
    end
  end

  // leaves in_valid high so back-to-back ticks need no re-raise
  task automatic send_tick(logic d);
    in_valid <= 1'b1;
    data_bit <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_ticks(int n);
    int left;
    int burst;
    int gap;
    left = n;
    while (left > 0) begin
      burst = idling ? $urandom_range(40, 1) : left;
      for (int i = 0; i < burst && left > 0; i++) begin
        send_tick(1'($urandom_range(1, 0)));
        left--;
      end
      if (idling && left > 0) begin
        gap = $urandom_range(12, 0);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic drain();
    int waited;
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    sb.report_leftovers();
  endtask

  // leaves cfg_valid high; set_config lowers it after the last transfer
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(logic [CfgW-1:0] h, logic [CfgW-1:0] c, logic [CfgW-1:0] s);
    cfg_write(REG_HALF_PERIOD, h);
    cfg_write(REG_TONE_CYCLES, c);
    cfg_write(REG_SILENT, s);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CfgW-1:0] pick_value(int width, int top);
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 8)  return '0;
    if (roll < 13) return CfgW'((1 << width) - 1);
    if (roll < 18) return CfgW'($urandom);
    return CfgW'($urandom_range(top, 1));
  endfunction

  initial begin : stimulus
    logic [11:0] dir_bits;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults, then zero registers cut the long tone mid-symbol
    idling = 1'b0;
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    drain();
    set_config('0, '0, '0);
    dir_bits = 12'b0110_0100_1110;
    for (int i = 0; i < 10; i++) send_tick(dir_bits[i]);
    drain();
    // unmapped index is ignored; upper data bits are masked per register
    cfg_write(REG_UNMAPPED, 24'hFFFFFF);
    set_config(24'hF00002, 24'hFFFC03, 24'h000003);
    for (int i = 0; i < 12; i++) send_tick(~dir_bits[i]);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // set_config follows at once and lowers cfg_valid afterwards
      if ($urandom_range(4, 0) == 0)
        cfg_write(REG_UNMAPPED, CfgW'($urandom));
      if (phase == 0)
        set_config(CfgW'((1 << HalfW) - 1), CfgW'((1 << CyclesW) - 1),
                   CfgW'((1 << SilentW) - 1));
      else if (phase == 1)
        set_config(24'd1, 24'd2, 24'd3);
      else
        set_config(pick_value(HalfW, 4), pick_value(CyclesW, 3), pick_value(SilentW, 8));
      if (phase == 4) begin
        // sender keeps offering through the hold so the block backs up
        idling    = 1'b0;
        long_hold = 1'b1;
      end else begin
        idling = ($urandom_range(3, 0) != 0);
      end
      run_ticks($urandom_range(90, 40));
      drain();
    end

    if (sb.failures == 0)
      $display("PASS diff_manchester_ook_tone_tx");
    else
      $display("FAIL diff_manchester_ook_tone_tx");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL diff_manchester_ook_tone_tx");
    $finish;
  end

endmodule
